// ===== hdl/ibe_pkg.sv =====
// Package for the IR bearing estimator: item structs, register codes,
// fixed-point constants and the CORDIC arctangent table. No dependencies.
package ibe_pkg;

  localparam int NumSensors = 6;
  localparam int ReadingW   = 10;
  localparam int SlotW      = 3;
  localparam int MinWeightW = 13;
  localparam int BearingW   = 16;

  // CORDIC datapath widths: pi is 2^31 in the angle accumulator.
  localparam int CordW    = 32;
  localparam int AccW     = 34;
  localparam int AtanLen  = 24;
  localparam int BinShift = 16;

  localparam logic [SlotW-1:0]      OwnSlotReset   = 3'd0;
  localparam logic [MinWeightW-1:0] MinWeightReset = 13'd30;

  // round(sqrt(3) * 2^16)
  localparam logic signed [17:0] SqrtThreeQ16 = 18'sd113512;
  localparam logic signed [AccW-1:0] QuarterTurn = 34'sd1073741824;
  localparam logic signed [AccW-1:0] RoundHalf   = 34'sd32768;

  // atan(2^-i) with pi = 2^31.
  localparam logic [31:0] AtanTable [AtanLen] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CfgOwnSlot   = 2'd0,
    CfgMinWeight = 2'd1
  } ibe_cfg_idx_e;

  typedef struct packed {
    logic                  action;
    logic [SlotW-1:0]      slot_index;
    logic [ReadingW-1:0]   reading_0;
    logic [ReadingW-1:0]   reading_1;
    logic [ReadingW-1:0]   reading_2;
    logic [ReadingW-1:0]   reading_3;
    logic [ReadingW-1:0]   reading_4;
    logic [ReadingW-1:0]   reading_5;
  } ibe_in_t;

  typedef struct packed {
    logic [SlotW-1:0]           neighbor_index;
    logic                       detected;
    logic signed [BearingW-1:0] bearing;
  } ibe_out_t;

  typedef struct packed {
    logic [SlotW-1:0]      own_slot_index;
    logic [MinWeightW-1:0] min_total_weight;
  } ibe_cfg_t;

  // Payload handed from cell to cell along the CORDIC chain.
  typedef struct packed {
    logic [SlotW-1:0]        slot;
    logic                    det;
    logic                    zero;
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [AccW-1:0]  acc;
  } ibe_cordic_t;

endpackage

// ===== hdl/ibe_front.sv =====
// Front end of the bearing estimator: ambient baseline store, clamped weights,
// detection decision and the vector setup for the CORDIC chain. Uses ibe_pkg.
module ibe_front #(
  parameter int ADC_BITS = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ibe_pkg::ibe_in_t     in_data_i,
  input  ibe_pkg::ibe_cfg_t    cfg_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ibe_pkg::ibe_cordic_t out_data_o
);
  import ibe_pkg::*;

  localparam int AmbW = (ADC_BITS < ReadingW) ? ADC_BITS : ReadingW;
  localparam int TotW = AmbW + 3;
  localparam int SxW  = AmbW + 4;
  localparam int SyW  = AmbW + 3;
  localparam int CmpW = (TotW > MinWeightW) ? TotW : MinWeightW;

  logic [ReadingW-1:0]   rd    [NumSensors];
  logic [AmbW-1:0]       amb_q [NumSensors];
  logic [AmbW-1:0]       w     [NumSensors];
  logic signed [SxW-1:0] wx    [NumSensors];
  logic [TotW-1:0]       total;
  logic                  det;
  logic signed [SxW-1:0] sx;
  logic signed [SyW-1:0] sy;
  logic                  amb_write;
  logic                  s0_ready;
  logic                  s1_ready;

  logic                  s0_valid_q;
  logic [SlotW-1:0]      s0_slot_q;
  logic                  s0_det_q;
  logic signed [SxW-1:0] s0_sx_q;
  logic signed [SyW-1:0] s0_sy_q;

  logic                  s1_valid_q;
  ibe_cordic_t           s1_d;
  ibe_cordic_t           s1_q;

  assign rd[0] = in_data_i.reading_0;
  assign rd[1] = in_data_i.reading_1;
  assign rd[2] = in_data_i.reading_2;
  assign rd[3] = in_data_i.reading_3;
  assign rd[4] = in_data_i.reading_4;
  assign rd[5] = in_data_i.reading_5;

  // Ready travels back through the two front stages; bubbles are filled.
  assign s1_ready   = !s1_valid_q || out_ready_i;
  assign s0_ready   = !s0_valid_q || s1_ready;
  assign in_stall_o = !s0_ready;
  assign amb_write  = in_valid_i && s0_ready && !in_data_i.action;

  // Weight of each sensor is the drop below ambient, clamped at zero.
  always_comb begin
    total = '0;
    for (int k = 0; k < NumSensors; k++) begin
      if (amb_q[k] > rd[k][AmbW-1:0]) begin
        w[k] = amb_q[k] - rd[k][AmbW-1:0];
      end else begin
        w[k] = '0;
      end
      wx[k] = signed'(SxW'(w[k]));
      total = total + TotW'(w[k]);
    end
  end

  assign det = (in_data_i.slot_index != cfg_i.own_slot_index) &&
               (CmpW'(total) >= CmpW'(cfg_i.min_total_weight));

  // Projections on the sensor axes: x scaled by two, y by 2/sqrt(3); both integer.
  assign sx = (wx[0] <<< 1) + wx[1] - wx[2] - (wx[3] <<< 1) - wx[4] + wx[5];
  assign sy = SyW'(wx[1] + wx[2] - wx[4] - wx[5]);

  // Ambient baseline store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumSensors; k++) begin
        amb_q[k] <= '0;
      end
    end else if (amb_write) begin
      for (int k = 0; k < NumSensors; k++) begin
        amb_q[k] <= rd[k][AmbW-1:0];
      end
    end
  end

  // Stage 0: weights reduced to the two axis sums. Ambient items leave a bubble.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (s0_ready) begin
      s0_valid_q <= in_valid_i && in_data_i.action;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_ready && in_valid_i && in_data_i.action) begin
      s0_slot_q <= in_data_i.slot_index;
      s0_det_q  <= det;
      s0_sx_q   <= sx;
      s0_sy_q   <= sy;
    end
  end

  // Stage 1: scale to Q16, then turn left-half-plane vectors by a quarter turn.
  always_comb begin
    logic signed [CordW-1:0] xe;
    logic signed [CordW-1:0] ye;
    xe = {{(CordW - SxW - BinShift){s0_sx_q[SxW-1]}}, s0_sx_q, {BinShift{1'b0}}};
    ye = CordW'(s0_sy_q) * CordW'(SqrtThreeQ16);
    s1_d.slot = s0_slot_q;
    s1_d.det  = s0_det_q;
    s1_d.zero = (s0_sx_q == '0) && (s0_sy_q == '0);
    if (s0_sx_q[SxW-1] && !ye[CordW-1]) begin
      s1_d.x   = ye;
      s1_d.y   = -xe;
      s1_d.acc = QuarterTurn;
    end else if (s0_sx_q[SxW-1]) begin
      s1_d.x   = -ye;
      s1_d.y   = xe;
      s1_d.acc = -QuarterTurn;
    end else begin
      s1_d.x   = xe;
      s1_d.y   = ye;
      s1_d.acc = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && s0_valid_q) begin
      s1_q <= s1_d;
    end
  end

  assign out_valid_o = s1_valid_q;
  assign out_data_o  = s1_q;

  // An ambient item never enters the chain.
  a_amb_no_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    amb_write |=> !s0_valid_q)
    else $error("ambient item entered the bearing pipeline");

  // The zero-vector flag matches the vector handed to the chain.
  a_zero_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_q.zero |-> (s1_q.x == '0) && (s1_q.y == '0))
    else $error("zero flag set on a nonzero vector");

  // Only the ready chain can hold an item back at the input.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s0_valid_q && s1_valid_q && !out_ready_i)
    else $error("front stalls with room in its stages");

endmodule

// ===== hdl/ibe_cordic_cell.sv =====
// One vectoring CORDIC cell: a single micro-rotation toward y = 0 with its
// pipeline register and handshake. Uses ibe_pkg for the payload and atan table.
module ibe_cordic_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 up_valid_i,
  output logic                 up_ready_o,
  input  ibe_pkg::ibe_cordic_t up_data_i,
  output logic                 dn_valid_o,
  input  logic                 dn_ready_i,
  output ibe_pkg::ibe_cordic_t dn_data_o
);
  import ibe_pkg::*;

  localparam logic signed [AccW-1:0] AtanStep = AccW'(AtanTable[STAGE]);

  logic                    valid_q;
  ibe_cordic_t             data_d;
  ibe_cordic_t             data_q;
  logic signed [CordW-1:0] xs;
  logic signed [CordW-1:0] ys;

  assign up_ready_o = !valid_q || dn_ready_i;

  // Floor shifts of both coordinates, then rotate toward the x axis.
  assign xs = up_data_i.x >>> STAGE;
  assign ys = up_data_i.y >>> STAGE;

  always_comb begin
    data_d = up_data_i;
    if (!up_data_i.y[CordW-1]) begin
      data_d.x   = up_data_i.x + ys;
      data_d.y   = up_data_i.y - xs;
      data_d.acc = up_data_i.acc + AtanStep;
    end else begin
      data_d.x   = up_data_i.x - ys;
      data_d.y   = up_data_i.y + xs;
      data_d.acc = up_data_i.acc - AtanStep;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o && up_valid_i) begin
      data_q <= data_d;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_data_o  = data_q;

endmodule

// ===== hdl/ir_bearing_estimator.sv =====
// Top level of the IR bearing estimator: configuration registers, front end,
// CORDIC cell chain and result register. Uses ibe_pkg, ibe_front, ibe_cordic_cell.

// Takes one item per clock cycle when the output side keeps up. An ambient item
// (action 0) replaces the six-entry baseline and yields no result; a slot item
// yields one result after passing through the two front stages, one stage per
// CORDIC cell and the result register, each cell doing one micro-rotation.
// Every stage has its own valid bit and the ready signal runs back through the
// chain, so empty stages fill while a result waits; in_stall_o rises only when
// every stage holds an item and out_stall_i is high. Configuration writes are
// always ready and must be made while no slot item is in flight.
module ir_bearing_estimator #(
  parameter int CORDIC_STAGES = 16,
  parameter int ADC_BITS      = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  ibe_pkg::ibe_in_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output ibe_pkg::ibe_out_t               out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  ibe_pkg::ibe_cfg_idx_e           cfg_index_i,
  input  logic [ibe_pkg::MinWeightW-1:0]  cfg_data_i
);
  import ibe_pkg::*;

  ibe_cfg_t    cfg_q;
  logic        chain_valid [CORDIC_STAGES+1];
  logic        chain_ready [CORDIC_STAGES+1];
  ibe_cordic_t chain_data  [CORDIC_STAGES+1];
  logic        out_valid_q;
  ibe_out_t    out_d;
  ibe_out_t    out_q;
  logic        out_ready;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_slot_index   <= OwnSlotReset;
      cfg_q.min_total_weight <= MinWeightReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgOwnSlot:   cfg_q.own_slot_index   <= cfg_data_i[SlotW-1:0];
        CfgMinWeight: cfg_q.min_total_weight <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ibe_front #(
    .ADC_BITS (ADC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cfg_i       (cfg_q),
    .out_valid_o (chain_valid[0]),
    .out_ready_i (chain_ready[0]),
    .out_data_o  (chain_data[0])
  );

  // Row of CORDIC cells, one micro-rotation each.
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    ibe_cordic_cell #(
      .STAGE (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .up_valid_i (chain_valid[i]),
      .up_ready_o (chain_ready[i]),
      .up_data_i  (chain_data[i]),
      .dn_valid_o (chain_valid[i+1]),
      .dn_ready_i (chain_ready[i+1]),
      .dn_data_o  (chain_data[i+1])
    );
  end

  // Result register: round the angle to a 16-bit binary angle.
  assign out_ready                   = !out_valid_q || !out_stall_i;
  assign chain_ready[CORDIC_STAGES]  = out_ready;

  always_comb begin
    logic signed [AccW-1:0] rnd;
    rnd                  = chain_data[CORDIC_STAGES].acc + RoundHalf;
    out_d.neighbor_index = chain_data[CORDIC_STAGES].slot;
    out_d.detected       = chain_data[CORDIC_STAGES].det;
    if (chain_data[CORDIC_STAGES].det && !chain_data[CORDIC_STAGES].zero) begin
      out_d.bearing = rnd[BinShift+BearingW-1:BinShift];
    end else begin
      out_d.bearing = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= chain_valid[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && chain_valid[CORDIC_STAGES]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A result that is not detected carries a zero bearing.
  a_undetected_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.detected |-> out_data_o.bearing == '0)
    else $error("undetected result with nonzero bearing");

  // The input is held back only when a result is waiting and stalled.
  a_stall_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  // A result that is taken frees the result register for the last cell.
  a_result_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !chain_valid[CORDIC_STAGES] |=> !out_valid_o)
    else $error("result register kept a taken result");

endmodule
